### src/ps2m_pkg.sv
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared constants, codes and helper functions for the PS/2 mouse device.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2m_pkg;

  // sizes
  localparam int FIFO_DEPTH = 16;
  localparam int COORD_BITS = 16;
  localparam int DELTA_BITS = 20;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_CNT_W  = 5;
  localparam int SUM_W      = ((DELTA_BITS > COORD_BITS + 1) ? DELTA_BITS : COORD_BITS + 1) + 1;

  // action codes
  localparam logic [2:0] ACT_CMD    = 3'd0;
  localparam logic [2:0] ACT_RAW    = 3'd1;
  localparam logic [2:0] ACT_MOVE   = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_TOGGLE = 3'd4;

  // host command bytes
  localparam logic [7:0] CMD_RESET    = 8'hff;
  localparam logic [7:0] CMD_DEFAULTS = 8'hf6;
  localparam logic [7:0] CMD_DISABLE  = 8'hf5;
  localparam logic [7:0] CMD_ENABLE   = 8'hf4;
  localparam logic [7:0] CMD_RATE     = 8'hf3;
  localparam logic [7:0] CMD_ID       = 8'hf2;
  localparam logic [7:0] CMD_REMOTE   = 8'hf0;
  localparam logic [7:0] CMD_DATA     = 8'heb;
  localparam logic [7:0] CMD_STREAM   = 8'hea;
  localparam logic [7:0] CMD_STATUS   = 8'he9;
  localparam logic [7:0] CMD_RES      = 8'he8;

  // reply bytes
  localparam logic [7:0] BYTE_BAT  = 8'haa;
  localparam logic [7:0] BYTE_ACK  = 8'hfa;
  localparam logic [7:0] DEVICE_ID = 8'h00;

  // status byte layout and defaults
  localparam int         ST_REMOTE_BIT = 6;
  localparam int         ST_ENABLE_BIT = 5;
  localparam logic [7:0] STATUS_DFLT   = 8'h20;
  localparam logic [7:0] RES_DFLT      = 8'd4;
  localparam logic [7:0] RATE_DFLT     = 8'd100;

  // pending argument codes
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_RATE = 2'd1;
  localparam logic [1:0] PEND_RES  = 2'd2;

  localparam logic signed [SUM_W-1:0]      SAT_HI = SUM_W'((2 ** (DELTA_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0]      SAT_LO = ~SAT_HI;
  localparam logic signed [DELTA_BITS-1:0] AX_POS = DELTA_BITS'(255);
  localparam logic signed [DELTA_BITS-1:0] AX_NEG = -DELTA_BITS'(255);

  typedef struct packed {
    logic [7:0] val;
    logic       sgn;
    logic       ovf;
  } axis_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic signed [DELTA_BITS-1:0] sat_delta(
    input logic signed [SUM_W-1:0] v
  );
    if (v > SAT_HI) begin
      sat_delta = DELTA_BITS'(SAT_HI);
    end else if (v < SAT_LO) begin
      sat_delta = DELTA_BITS'(SAT_LO);
    end else begin
      sat_delta = DELTA_BITS'(v);
    end
  endfunction

  // one packet axis byte with its sign and overflow flags
  function automatic axis_t pack_axis(input logic signed [DELTA_BITS-1:0] d);
    axis_t a;
    a.sgn = d[DELTA_BITS-1];
    a.ovf = 1'b0;
    a.val = d[7:0];
    if (!a.sgn && d > AX_POS) begin
      a.ovf = 1'b1;
      a.val = 8'hff;
    end else if (a.sgn && d < AX_NEG) begin
      a.ovf = 1'b1;
      a.val = 8'hff;
    end
    pack_axis = a;
  endfunction

endpackage

`default_nettype wire

### src/ps2_mouse_device.sv
// ----------------------------------------------------------------------------
// ps2_mouse_device
// PS/2 mouse device: host command handling, motion packets, reply byte FIFO.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_stall  | action, data byte, x, y, buttons, en
//  out_    | output    | out_valid/out_stall| read data, empty, fifo count, notify
//
// one word at a time: exec runs it, fin registers the result once the output
// register is free; a toggle, an unused code or an empty read go from exec to
// fin, a read passes rdwait for the ram output, motion words pass push, and
// replies and a packet go through push and pkt into the ram one byte per cycle
// (up to four bytes per word); the next word is taken the cycle after fin, even
// while the result waits behind out_stall; rst_n is synchronous, ram uncleared
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_device (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [2:0]                       in_action,
  input  wire logic [7:0]                       in_data_byte,
  input  wire logic [ps2m_pkg::COORD_BITS-1:0]  in_pos_x,
  input  wire logic [ps2m_pkg::COORD_BITS-1:0]  in_pos_y,
  input  wire logic [2:0]                       in_buttons,
  input  wire logic                             in_enable,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_read_data,
  output logic                                  out_read_empty,
  output logic [ps2m_pkg::OUT_CNT_W-1:0]        out_fifo_count,
  output logic                                  out_notify
);

  localparam int PTR_W      = ps2m_pkg::PTR_W;
  localparam int CNT_W      = ps2m_pkg::CNT_W;
  localparam int DELTA_BITS = ps2m_pkg::DELTA_BITS;
  localparam int COORD_BITS = ps2m_pkg::COORD_BITS;
  localparam int SUM_W      = ps2m_pkg::SUM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_PUSH,
    ST_PKT,
    ST_FIN
  } state_t;

  state_t state_r;

  // latched input word
  logic [2:0]            act_r;
  logic [7:0]            data_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [2:0]            btn_r;
  logic                  en_r;

  // device state
  logic [PTR_W-1:0]             rd_ptr_r;
  logic [PTR_W-1:0]             wr_ptr_r;
  logic [CNT_W-1:0]             count_r;
  logic [7:0]                   status_r;
  logic [7:0]                   res_val_r;
  logic [7:0]                   rate_val_r;
  logic [1:0]                   pend_r;
  logic                         ctrl_on_r;
  logic [COORD_BITS-1:0]        last_x_r;
  logic [COORD_BITS-1:0]        last_y_r;
  logic signed [DELTA_BITS-1:0] acc_dx_r;
  logic signed [DELTA_BITS-1:0] acc_dy_r;

  // byte push queue, head in slot 0
  logic [7:0] push_q_r [4];
  logic [2:0] push_left_r;
  logic       pkt_pend_r;

  // result being built
  logic       res_empty_r;
  logic       res_rd_r;
  logic       res_notify_r;

  // output register
  logic                            out_valid_r;
  logic [7:0]                      out_data_r;
  logic                            out_empty_r;
  logic [ps2m_pkg::OUT_CNT_W-1:0]  out_cnt_r;
  logic                            out_notify_r;

  // fifo ram
  logic [7:0] fifo_mem [ps2m_pkg::FIFO_DEPTH];
  logic [7:0] mem_rdata_r;
  logic       mem_we;
  logic       mem_re;

  // motion arithmetic
  logic signed [SUM_W-1:0]      sum_x;
  logic signed [SUM_W-1:0]      sum_y;
  logic signed [DELTA_BITS-1:0] acc_dx_nxt;
  logic signed [DELTA_BITS-1:0] acc_dy_nxt;
  logic [7:0]                   btn_status;
  ps2m_pkg::axis_t              ax_x;
  ps2m_pkg::axis_t              ax_y;
  logic [7:0]                   pkt_hdr;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_read_empty = out_empty_r;
  assign out_fifo_count = out_cnt_r;
  assign out_notify     = out_notify_r;

  // y motion is last minus new
  always_comb begin
    sum_x = SUM_W'(acc_dx_r) + SUM_W'($signed({1'b0, px_r}))
          - SUM_W'($signed({1'b0, last_x_r}));
    sum_y = SUM_W'(acc_dy_r) + SUM_W'($signed({1'b0, last_y_r}))
          - SUM_W'($signed({1'b0, py_r}));
    acc_dx_nxt = ps2m_pkg::sat_delta(sum_x);
    acc_dy_nxt = ps2m_pkg::sat_delta(sum_y);
    // middle and right swap places in the status byte
    btn_status = {status_r[7:3], btn_r[1], btn_r[2], btn_r[0]};
  end

  // packet bytes from the stored deltas
  always_comb begin
    ax_x    = ps2m_pkg::pack_axis(acc_dx_r);
    ax_y    = ps2m_pkg::pack_axis(acc_dy_r);
    pkt_hdr = {ax_y.ovf, ax_x.ovf, ax_y.sgn, ax_x.sgn, 1'b1, status_r[2:0]};
  end

  // a push into a full fifo is dropped
  assign mem_we = (state_r == ST_PUSH) && (push_left_r != 3'd0)
                  && (count_r < CNT_W'(ps2m_pkg::FIFO_DEPTH));
  assign mem_re = (state_r == ST_EXEC) && (act_r == ps2m_pkg::ACT_READ)
                  && (count_r != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fifo_mem[wr_ptr_r] <= push_q_r[0];
    end
    if (mem_re) begin
      mem_rdata_r <= fifo_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      status_r    <= ps2m_pkg::STATUS_DFLT;
      res_val_r   <= ps2m_pkg::RES_DFLT;
      rate_val_r  <= ps2m_pkg::RATE_DFLT;
      pend_r      <= ps2m_pkg::PEND_NONE;
      ctrl_on_r   <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      acc_dx_r    <= '0;
      acc_dy_r    <= '0;
      push_left_r <= 3'd0;
      pkt_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r        <= in_action;
            data_r       <= in_data_byte;
            px_r         <= in_pos_x;
            py_r         <= in_pos_y;
            btn_r        <= in_buttons;
            en_r         <= in_enable;
            res_empty_r  <= 1'b0;
            res_rd_r     <= 1'b0;
            res_notify_r <= 1'b0;
            push_left_r  <= 3'd0;
            pkt_pend_r   <= 1'b0;
            state_r      <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          unique case (act_r)
            ps2m_pkg::ACT_CMD, ps2m_pkg::ACT_RAW: begin
              // every host write empties the fifo first
              rd_ptr_r    <= '0;
              wr_ptr_r    <= '0;
              count_r     <= '0;
              push_q_r[0] <= ps2m_pkg::BYTE_ACK;
              push_left_r <= 3'd1;
              state_r     <= ST_PUSH;
              if (pend_r != ps2m_pkg::PEND_NONE) begin
                if (pend_r == ps2m_pkg::PEND_RATE) begin
                  rate_val_r <= data_r;
                end else begin
                  res_val_r <= data_r;
                end
                pend_r <= ps2m_pkg::PEND_NONE;
              end else if (act_r == ps2m_pkg::ACT_RAW) begin
                push_q_r[0] <= data_r;
              end else begin
                unique case (data_r)
                  ps2m_pkg::CMD_RESET, ps2m_pkg::CMD_DEFAULTS: begin
                    status_r   <= ps2m_pkg::STATUS_DFLT;
                    res_val_r  <= ps2m_pkg::RES_DFLT;
                    rate_val_r <= ps2m_pkg::RATE_DFLT;
                    last_x_r   <= '0;
                    last_y_r   <= '0;
                    acc_dx_r   <= '0;
                    acc_dy_r   <= '0;
                    if (data_r == ps2m_pkg::CMD_RESET) begin
                      // ack, self test passed, device id
                      push_q_r[1] <= ps2m_pkg::BYTE_BAT;
                      push_q_r[2] <= ps2m_pkg::DEVICE_ID;
                      push_left_r <= 3'd3;
                    end
                  end
                  ps2m_pkg::CMD_DISABLE: status_r[ps2m_pkg::ST_ENABLE_BIT] <= 1'b0;
                  ps2m_pkg::CMD_ENABLE:  status_r[ps2m_pkg::ST_ENABLE_BIT] <= 1'b1;
                  ps2m_pkg::CMD_RATE:    pend_r <= ps2m_pkg::PEND_RATE;
                  ps2m_pkg::CMD_RES:     pend_r <= ps2m_pkg::PEND_RES;
                  ps2m_pkg::CMD_ID: begin
                    push_q_r[1] <= ps2m_pkg::DEVICE_ID;
                    push_left_r <= 3'd2;
                  end
                  ps2m_pkg::CMD_REMOTE: status_r[ps2m_pkg::ST_REMOTE_BIT] <= 1'b1;
                  ps2m_pkg::CMD_STREAM: status_r[ps2m_pkg::ST_REMOTE_BIT] <= 1'b0;
                  ps2m_pkg::CMD_DATA:   pkt_pend_r <= 1'b1;
                  ps2m_pkg::CMD_STATUS: begin
                    push_q_r[1] <= status_r;
                    push_q_r[2] <= res_val_r;
                    push_q_r[3] <= rate_val_r;
                    push_left_r <= 3'd4;
                  end
                  default: ;  // unknown command: ack only
                endcase
              end
            end

            ps2m_pkg::ACT_MOVE: begin
              acc_dx_r <= acc_dx_nxt;
              acc_dy_r <= acc_dy_nxt;
              last_x_r <= px_r;
              last_y_r <= py_r;
              status_r <= btn_status;
              if (status_r[ps2m_pkg::ST_ENABLE_BIT] && ctrl_on_r) begin
                pkt_pend_r   <= 1'b1;
                res_notify_r <= 1'b1;
              end
              state_r <= ST_PUSH;
            end

            ps2m_pkg::ACT_READ: begin
              if (count_r != '0) begin
                // ram read issued this cycle
                rd_ptr_r <= ps2m_pkg::ptr_inc(rd_ptr_r);
                count_r  <= count_r - CNT_W'(1);
                res_rd_r <= 1'b1;
                state_r  <= ST_RDWAIT;
              end else begin
                res_empty_r <= 1'b1;
                state_r     <= ST_FIN;
              end
            end

            ps2m_pkg::ACT_TOGGLE: begin
              ctrl_on_r <= en_r;
              if (!en_r) begin
                rd_ptr_r <= '0;
                wr_ptr_r <= '0;
                count_r  <= '0;
              end
              state_r <= ST_FIN;
            end

            default: state_r <= ST_FIN;  // unused action codes
          endcase
        end

        ST_RDWAIT: begin
          state_r <= ST_FIN;
        end

        ST_PUSH: begin
          if (push_left_r != 3'd0) begin
            if (mem_we) begin
              wr_ptr_r <= ps2m_pkg::ptr_inc(wr_ptr_r);
              count_r  <= count_r + CNT_W'(1);
            end
            push_q_r[0] <= push_q_r[1];
            push_q_r[1] <= push_q_r[2];
            push_q_r[2] <= push_q_r[3];
            push_left_r <= push_left_r - 3'd1;
          end else if (pkt_pend_r) begin
            state_r <= ST_PKT;
          end else begin
            state_r <= ST_FIN;
          end
        end

        ST_PKT: begin
          // deltas clear whether or not the packet fits
          pkt_pend_r <= 1'b0;
          acc_dx_r   <= '0;
          acc_dy_r   <= '0;
          if (count_r < CNT_W'(ps2m_pkg::FIFO_DEPTH - 3)) begin
            push_q_r[0] <= pkt_hdr;
            push_q_r[1] <= ax_x.val;
            push_q_r[2] <= ax_y.val;
            push_left_r <= 3'd3;
          end
          state_r <= ST_PUSH;
        end

        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= res_rd_r ? mem_rdata_r : 8'h00;
            out_empty_r  <= res_empty_r;
            out_cnt_r    <= ps2m_pkg::OUT_CNT_W'(count_r);
            out_notify_r <= res_notify_r && (count_r != '0);
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ps2m_pkg::FIFO_DEPTH))
    else $error("fifo count above depth");

  // an empty read returns zero and an empty fifo
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_data_r == 8'h00 && out_cnt_r == '0))
    else $error("empty read result inconsistent");

  // notify only with bytes waiting
  a_notify_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_notify_r) |-> (out_cnt_r != '0))
    else $error("notify with empty fifo");

  // the ram is only written while bytes are being queued
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_PUSH && !in_stall == 1'b0))
    else $error("fifo write outside push");

endmodule

`default_nettype wire

### verif/ps2_mouse_device_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_device_tb
// Self-checking bench for the PS/2 mouse device. A short directed run walks
// the host commands, argument bytes and motion packets, then random traffic
// runs under changing idle and stall patterns. Every accepted word updates a
// shadow copy of the device, and each reply word is checked field by field.
// ----------------------------------------------------------------------------
module ps2_mouse_device_tb;
  import ps2m_pkg::*;

  localparam int    CLK_HALF      = 6;
  localparam int    RESET_CYCLES  = 7;
  localparam int    TAIL_CYCLES   = 20;
  localparam int    SETTLE_LIMIT  = 20000;
  localparam int    MAX_GAP       = 40;
  localparam int    HOLD_CYCLES   = 400;
  localparam int    MAX_PRINTS    = 100;
  localparam longint RUN_LIMIT_NS = 10_000_000;

  localparam int DELTA_HI = (1 << (DELTA_BITS - 1)) - 1;
  localparam int DELTA_LO = -DELTA_HI - 1;
  localparam int AXIS_MAX = 255;

  // action codes past the toggle do nothing
  localparam logic [2:0] ACT_LAST = 3'd7;

  // packet header bits
  localparam logic [7:0] PKT_SYNC   = 8'h08;
  localparam logic [7:0] PKT_X_SIGN = 8'h10;
  localparam logic [7:0] PKT_Y_SIGN = 8'h20;
  localparam logic [7:0] PKT_X_OVF  = 8'h40;
  localparam logic [7:0] PKT_Y_OVF  = 8'h80;
  localparam logic [7:0] AXIS_FULL  = 8'hff;

  // clock, reset and both channels; every input known from time zero
  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_action    = ACT_READ;
  logic [7:0]            in_data_byte = '0;
  logic [COORD_BITS-1:0] in_pos_x     = '0;
  logic [COORD_BITS-1:0] in_pos_y     = '0;
  logic [2:0]            in_buttons   = '0;
  logic                  in_enable    = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [7:0]            out_read_data;
  logic                  out_read_empty;
  logic [OUT_CNT_W-1:0]  out_fifo_count;
  logic                  out_notify;

  // one reply word as the device should give it
  typedef struct packed {
    logic [7:0]           read_data;
    logic                 read_empty;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic                 notify;
  } reply_t;

  reply_t replies_due[$];
  reply_t due_reply;

  // shadow copy of the device state
  logic [7:0]            shadow_mem [FIFO_DEPTH];
  int                    rd_at, wr_at, held;
  logic [7:0]            status_q, resol_q, rate_q;
  logic [1:0]            arg_wait;
  logic                  reporting;
  logic [COORD_BITS-1:0] last_px, last_py;
  int                    sum_dx, sum_dy;

  // run statistics and knobs
  int error_count     = 0;
  int words_sent      = 0;
  int replies_seen    = 0;
  int packets_made    = 0;
  int packets_refused = 0;
  int empty_reads     = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_left       = 0;

  ps2_mouse_device u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_buttons     (in_buttons),
    .in_enable      (in_enable),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_read_empty (out_read_empty),
    .out_fifo_count (out_fifo_count),
    .out_notify     (out_notify)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- shadow model

  task automatic clear_replies();
    rd_at = 0;
    wr_at = 0;
    held  = 0;
  endtask

  // a byte pushed into a full queue is lost
  task automatic push_reply_byte(input logic [7:0] b);
    if (held < FIFO_DEPTH) begin
      shadow_mem[wr_at] = b;
      wr_at = (wr_at + 1) % FIFO_DEPTH;
      held++;
    end
  endtask

  // device reset leaves the controller enable alone
  task automatic restore_defaults();
    clear_replies();
    status_q = STATUS_DFLT;
    resol_q  = RES_DFLT;
    rate_q   = RATE_DFLT;
    last_px  = '0;
    last_py  = '0;
    sum_dx   = 0;
    sum_dy   = 0;
  endtask

  function automatic int clamp_delta(input int v);
    if (v > DELTA_HI) return DELTA_HI;
    if (v < DELTA_LO) return DELTA_LO;
    return v;
  endfunction

  // beyond +-255 the axis byte pins at 0xff with overflow, sign kept
  function automatic logic [7:0] axis_byte(input int d, output logic neg, output logic ovf);
    neg = d < 0;
    ovf = (d > AXIS_MAX) || (d < -AXIS_MAX);
    return ovf ? AXIS_FULL : 8'(d);
  endfunction

  // deltas are cleared even when there is no room for the three bytes
  task automatic queue_packet();
    logic [7:0] hdr, bx, by;
    logic       xn, xo, yn, yo;
    bx  = axis_byte(sum_dx, xn, xo);
    by  = axis_byte(sum_dy, yn, yo);
    hdr = PKT_SYNC | {5'd0, status_q[2:0]};
    if (xn) hdr = hdr | PKT_X_SIGN;
    if (yn) hdr = hdr | PKT_Y_SIGN;
    if (xo) hdr = hdr | PKT_X_OVF;
    if (yo) hdr = hdr | PKT_Y_OVF;
    sum_dx = 0;
    sum_dy = 0;
    if (held < FIFO_DEPTH - 3) begin
      push_reply_byte(hdr);
      push_reply_byte(bx);
      push_reply_byte(by);
      packets_made++;
    end else begin
      packets_refused++;
    end
  endtask

  // any host write first empties the reply queue
  task automatic host_write(input logic [7:0] b, input logic raw);
    clear_replies();
    if (arg_wait != PEND_NONE) begin
      // argument byte for rate or resolution, whatever its kind
      if (arg_wait == PEND_RATE) rate_q = b;
      else resol_q = b;
      push_reply_byte(BYTE_ACK);
      arg_wait = PEND_NONE;
    end else if (raw) begin
      push_reply_byte(b);
    end else begin
      case (b)
        CMD_RESET, CMD_DEFAULTS: restore_defaults();
        CMD_DISABLE: status_q[ST_ENABLE_BIT] = 1'b0;
        CMD_ENABLE:  status_q[ST_ENABLE_BIT] = 1'b1;
        CMD_REMOTE:  status_q[ST_REMOTE_BIT] = 1'b1;
        CMD_STREAM:  status_q[ST_REMOTE_BIT] = 1'b0;
        CMD_RATE:    arg_wait = PEND_RATE;
        CMD_RES:     arg_wait = PEND_RES;
        default: ;
      endcase
      // every command byte, known or not, is acknowledged first
      push_reply_byte(BYTE_ACK);
      case (b)
        CMD_RESET: begin
          push_reply_byte(BYTE_BAT);
          push_reply_byte(DEVICE_ID);
        end
        CMD_ID: push_reply_byte(DEVICE_ID);
        CMD_DATA: queue_packet();
        CMD_STATUS: begin
          push_reply_byte(status_q);
          push_reply_byte(resol_q);
          push_reply_byte(rate_q);
        end
        default: ;
      endcase
    end
  endtask

  // apply one accepted word to the shadow and queue the reply it should give
  task automatic track_device(input logic [2:0] act, input logic [7:0] data,
                              input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py,
                              input logic [2:0] btn, input logic en);
    reply_t r;
    r = '0;
    case (act)
      ACT_CMD, ACT_RAW: host_write(data, act == ACT_RAW);
      ACT_MOVE: begin
        // y grows downward on screen, so y motion is old minus new
        sum_dx  = clamp_delta(sum_dx + int'(px) - int'(last_px));
        sum_dy  = clamp_delta(sum_dy + int'(last_py) - int'(py));
        last_px = px;
        last_py = py;
        // status order is left, right, middle
        status_q[2:0] = {btn[1], btn[2], btn[0]};
        if (status_q[ST_ENABLE_BIT] && reporting) begin
          queue_packet();
          r.notify = held > 0;
        end
      end
      ACT_READ: begin
        if (held > 0) begin
          r.read_data = shadow_mem[rd_at];
          rd_at = (rd_at + 1) % FIFO_DEPTH;
          held--;
        end else begin
          r.read_empty = 1'b1;
          empty_reads++;
        end
      end
      ACT_TOGGLE: begin
        reporting = en;
        if (!en) clear_replies();
      end
      default: ;
    endcase
    r.fifo_count = OUT_CNT_W'(held);
    replies_due.push_back(r);
  endtask

  // ---------------------------------------------------------------- driving

  // offer one word after a random idle gap; valid stays high after the
  // handshake so back-to-back words need no second assignment in a step
  task automatic send_word(input logic [2:0] act, input logic [7:0] data,
                           input logic [COORD_BITS-1:0] px,
                           input logic [COORD_BITS-1:0] py,
                           input logic [2:0] btn, input logic en);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_buttons   <= btn;
    in_enable    <= en;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
    track_device(act, data, px, py, btn, en);
  endtask

  // fields the action does not use carry noise
  task automatic send_plain(input logic [2:0] act, input logic [7:0] data);
    send_word(act, data, COORD_BITS'($urandom), COORD_BITS'($urandom), 3'($urandom),
              1'($urandom));
  endtask

  task automatic read_back(input int n);
    repeat (n) send_plain(ACT_READ, 8'($urandom));
  endtask

  // mostly small steps around the last point, sometimes a jump anywhere
  task automatic send_move();
    logic [COORD_BITS-1:0] px, py;
    if ($urandom_range(0, 3) == 0) begin
      px = COORD_BITS'($urandom);
      py = COORD_BITS'($urandom);
    end else begin
      px = last_px + COORD_BITS'($urandom_range(0, 600)) - COORD_BITS'(300);
      py = last_py + COORD_BITS'($urandom_range(0, 600)) - COORD_BITS'(300);
    end
    send_word(ACT_MOVE, 8'($urandom), px, py, 3'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 12))
      0:  return CMD_RESET;
      1:  return CMD_DEFAULTS;
      2:  return CMD_DISABLE;
      3:  return CMD_ENABLE;
      4:  return CMD_RATE;
      5:  return CMD_ID;
      6:  return CMD_REMOTE;
      7:  return CMD_DATA;
      8:  return CMD_STREAM;
      9:  return CMD_STATUS;
      10: return CMD_RES;
      default: return 8'($urandom);
    endcase
  endfunction

  // stop offering and wait for every reply, then let the pipe go quiet
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (replies_due.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  // receiver stall; a long hold-off is counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= $urandom_range(0, 99) < recv_stall_pct;
      end
    end
  end

  // values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (replies_due.size() == 0) begin
        flag_error("reply word with nothing due");
      end else begin
        due_reply = replies_due.pop_front();
        replies_seen++;
        if (out_read_data !== due_reply.read_data)
          flag_error($sformatf("read_data %h, want %h", out_read_data,
                               due_reply.read_data));
        if (out_read_empty !== due_reply.read_empty)
          flag_error($sformatf("read_empty %b, want %b", out_read_empty,
                               due_reply.read_empty));
        if (out_fifo_count !== due_reply.fifo_count)
          flag_error($sformatf("fifo_count %0d, want %0d", out_fifo_count,
                               due_reply.fifo_count));
        if (out_notify !== due_reply.notify)
          flag_error($sformatf("notify %b, want %b", out_notify, due_reply.notify));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset answers ack, self-test pass and id
  task automatic test_reset_reply();
    send_plain(ACT_CMD, CMD_RESET);
    read_back(3);
  endtask

  task automatic test_host_commands();
    send_plain(ACT_CMD, CMD_REMOTE);
    send_plain(ACT_CMD, CMD_RES);
    send_plain(ACT_RAW, 8'h03);        // argument may come as a raw write
    send_plain(ACT_CMD, CMD_RATE);
    send_plain(ACT_CMD, CMD_RESET);    // taken as the rate, not as a reset
    send_plain(ACT_CMD, CMD_STATUS);
    read_back(4);
    send_plain(ACT_CMD, CMD_DISABLE);
    send_plain(ACT_CMD, CMD_ENABLE);
    send_plain(ACT_CMD, CMD_STREAM);
    send_plain(ACT_CMD, CMD_ID);
    send_plain(ACT_CMD, 8'h00);        // unknown byte is only acknowledged
    send_plain(ACT_RAW, 8'hff);
    send_plain(ACT_CMD, CMD_DEFAULTS);
  endtask

  task automatic test_pointer_packets();
    send_word(ACT_TOGGLE, 8'($urandom), '0, '0, '0, 1'b1);
    // full swing right: x overflow, all buttons
    send_word(ACT_MOVE, 8'($urandom), '1, '0, 3'b111, 1'($urandom));
    // full swing back on both axes: negative overflow gives 0xff
    send_word(ACT_MOVE, 8'($urandom), '0, '1, 3'b000, 1'($urandom));
    send_plain(ACT_CMD, CMD_DATA);
    // disabled device keeps quiet on motion
    send_plain(ACT_CMD, CMD_DISABLE);
    send_word(ACT_MOVE, 8'($urandom), 16'd5, 16'hfffe, 3'b010, 1'($urandom));
    send_plain(ACT_LAST, 8'($urandom));
    // controller off empties the queue
    send_word(ACT_TOGGLE, 8'($urandom), '1, '1, '1, 1'b0);
    read_back(1);
    settle();
  endtask

  // one random scenario: a command and its reply, an argument pair, a run of
  // motion, a raw insert, a toggle, a spare code or a lone read
  task automatic random_burst();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_plain(ACT_CMD, pick_command());
      read_back(held + ($urandom_range(0, 3) == 0));
    end else if (pick < 45) begin
      send_plain(ACT_CMD, $urandom_range(0, 1) ? CMD_RATE : CMD_RES);
      send_plain($urandom_range(0, 1) ? ACT_RAW : ACT_CMD, 8'($urandom));
      read_back($urandom_range(0, 1));
    end else if (pick < 75) begin
      // six packets in a row run past the room check
      repeat ($urandom_range(1, 6)) send_move();
      read_back($urandom_range(0, held));
    end else if (pick < 85) begin
      send_plain(ACT_RAW, 8'($urandom));
      read_back($urandom_range(0, 2));
    end else if (pick < 92) begin
      send_word(ACT_TOGGLE, 8'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                3'($urandom), $urandom_range(0, 4) != 0);
    end else if (pick < 96) begin
      send_plain(3'($urandom_range(ACT_TOGGLE + 1, ACT_LAST)), 8'($urandom));
    end else begin
      read_back(1);
    end
  endtask

  task automatic test_random_mix(input int words, input int idle_pct, input int stall_pct);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = words_sent + words;
    while (words_sent < stop_at) random_burst();
    settle();
  endtask

  // receiver holds off for a long stretch while words keep coming, so the
  // result register fills and the input side has to stall
  task automatic test_result_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(ACT_TOGGLE, 8'($urandom), '0, '0, '0, 1'b1);
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      send_move();
      read_back(1);
    end
    settle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    restore_defaults();
    arg_wait  = PEND_NONE;
    reporting = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_reply();
    test_host_commands();
    test_pointer_packets();
    test_random_mix(480, 0, 0);
    test_random_mix(480, 66, 0);
    test_result_hold();
    test_random_mix(480, 0, 66);
    test_random_mix(480, 22, 22);

    if (replies_due.size() != 0)
      flag_error($sformatf("%0d reply words never came", replies_due.size()));

    $display("covered %0d words and checked %0d replies under idle and stall mixes",
             words_sent, replies_seen);
    $display("%0d motion packets queued, %0d refused for room, %0d reads found nothing",
             packets_made, packets_refused, empty_reads);
    if (error_count == 0) begin
      $display("ps2_mouse_device_tb: clean");
    end else begin
      $display("ps2_mouse_device_tb: errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("run limit reached, %0d reply words outstanding", replies_due.size());
    $display("ps2_mouse_device_tb: errors");
    $finish;
  end

endmodule
